// ===== rtl/twdp_pkg.sv =====
// package for the two-bit weight dot-product tile
// holds field widths, weight code extraction and the controller command struct
// depends on nothing
package twdp_pkg;

    localparam int ACT_W            = 8;
    localparam int WEIGHT_W         = 64;
    localparam int GROUP_W          = 4 * WEIGHT_W;
    localparam int CODE_W           = 2;
    localparam int SUM_W            = 32;
    localparam int COL_W            = 5;
    localparam int DEPTH_ROWS       = 4;
    localparam int WEIGHT_COLUMNS   = 32;
    localparam int TILE_COLUMNS_DEF = 32;
    // activation times a code of at most three, and the sum of four of them
    localparam int PROD_W           = ACT_W + CODE_W;
    localparam int TERM_W           = PROD_W + 2;
    // one code per depth row in each weight byte lane
    localparam logic [31:0] CODE_MASK = 32'h0303_0303;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;     // add the accepted group into every column
        logic shift;    // one column result taken, rotate the sums
    } t_ctrl_cmd;

    // code of depth row b for column c; columns past the weight group read as zero
    function automatic logic [CODE_W-1:0] weight_code(
        input logic [GROUP_W-1:0] w,
        input int                 c,
        input int                 b
    );
        int          j;
        int          f;
        int          n;
        logic [31:0] lanes;
        logic [7:0]  byte_val;
        j        = c % 8;
        f        = (c / 8) % 4;
        n        = 4 * j + b;
        byte_val = w[8*n +: 8];
        // pick field f of the byte by masking the shifted byte
        lanes    = 32'(byte_val >> (2 * f)) & CODE_MASK;
        if (c >= WEIGHT_COLUMNS) begin
            weight_code = '0;
        end else begin
            weight_code = lanes[CODE_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/two_bit_weight_dot_product_tile_core.sv =====
// top level of the two-bit weight dot-product tile
// joins twdp_ctrl and twdp_datapath; depends on twdp_pkg
//
// usage
//   input channel: i_in_valid / o_in_stall carries four signed activations,
//   256 bits of packed 2-bit weight codes and a last-group flag. a transaction
//   adds, for every column, activation times code over the four depth rows
//   into a wrapping 32-bit accumulator in the same cycle it is taken.
//   output channel: o_out_valid / i_out_stall carries column, sum and
//   last_column. a transaction marked last group is followed, from the next
//   cycle, by TILE_COLUMNS results in column order, the final one flagged.
//   throughput: one transaction per cycle for groups without the last flag;
//   after a last group the single result port drains one accumulator lane
//   per cycle while the receiver does not stall.
//   the input is stalled for the whole result stream.
//   a receiver stall simply holds the current result; nothing is lost.
//   after the stream the sums are cleared unless accumulate mode is set.
//   configuration: i_cfg_we writes i_cfg_data into accumulate mode; write it
//   only while idle.
//   reset (synchronous, active low) clears all sums and accumulate mode.
module two_bit_weight_dot_product_tile_core #(
    parameter int TILE_COLUMNS = twdp_pkg::TILE_COLUMNS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [twdp_pkg::ACT_W-1:0]   i_act_0,
    input  logic signed [twdp_pkg::ACT_W-1:0]   i_act_1,
    input  logic signed [twdp_pkg::ACT_W-1:0]   i_act_2,
    input  logic signed [twdp_pkg::ACT_W-1:0]   i_act_3,
    input  logic [twdp_pkg::WEIGHT_W-1:0]       i_weights_0,
    input  logic [twdp_pkg::WEIGHT_W-1:0]       i_weights_1,
    input  logic [twdp_pkg::WEIGHT_W-1:0]       i_weights_2,
    input  logic [twdp_pkg::WEIGHT_W-1:0]       i_weights_3,
    input  logic                                i_last_group,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [twdp_pkg::COL_W-1:0]          o_column,
    output logic signed [twdp_pkg::SUM_W-1:0]   o_sum,
    output logic                                o_last_column
);

    twdp_pkg::t_ctrl_cmd cmd;

    // sequencing
    twdp_ctrl #(
        .TILE_COLUMNS (TILE_COLUMNS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_last_group  (i_last_group),
        .o_in_stall    (o_in_stall),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_column      (o_column),
        .o_last_column (o_last_column),
        .o_cmd         (cmd)
    );

    // accumulator lanes
    twdp_datapath #(
        .TILE_COLUMNS (TILE_COLUMNS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .i_act_0     (i_act_0),
        .i_act_1     (i_act_1),
        .i_act_2     (i_act_2),
        .i_act_3     (i_act_3),
        .i_weights_0 (i_weights_0),
        .i_weights_1 (i_weights_1),
        .i_weights_2 (i_weights_2),
        .i_weights_3 (i_weights_3),
        .o_sum       (o_sum)
    );

endmodule

// ===== rtl/twdp_ctrl.sv =====
// controller of the two-bit weight dot-product tile
// sequences accumulation and the column-by-column result stream
// depends on twdp_pkg
module twdp_ctrl #(
    parameter int TILE_COLUMNS = twdp_pkg::TILE_COLUMNS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_last_group,
    output logic                      o_in_stall,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [twdp_pkg::COL_W-1:0] o_column,
    output logic                      o_last_column,
    output twdp_pkg::t_ctrl_cmd       o_cmd
);

    localparam int CNT_W = (TILE_COLUMNS > 1) ? $clog2(TILE_COLUMNS) : 1;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TILE_COLUMNS - 1);

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             in_acc;
    logic             out_acc;
    logic             at_last;

    // handshakes
    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = (r_state == S_EMIT);
    assign in_acc        = i_in_valid && !o_in_stall;
    assign out_acc       = o_out_valid && !i_out_stall;
    assign at_last       = (r_count == LAST_CNT);
    assign o_column      = twdp_pkg::COL_W'(r_count);
    assign o_last_column = at_last;

    // datapath commands
    assign o_cmd.load  = in_acc;
    assign o_cmd.shift = out_acc;

    // next state
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        case (r_state)
            S_IDLE: begin
                n_count = '0;
                if (in_acc && i_last_group) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_acc) begin
                    if (at_last) begin
                        n_state = S_IDLE;
                        n_count = '0;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
                n_count = '0;
            end
        endcase
    end

    // state and column counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // a group marked last starts the result stream
    a_last_starts_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_last_group) |=> o_out_valid)
        else $error("result stream did not start after last group");

    // the final column ends the stream
    a_final_ends_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_last_column) |=> (!o_out_valid && !o_in_stall))
        else $error("result stream ran past the final column");

    // the column count stays inside the tile
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_count <= LAST_CNT))
        else $error("column count beyond tile");

endmodule

// ===== rtl/twdp_datapath.sv =====
// datapath of the two-bit weight dot-product tile
// column accumulator lanes, rotating result line and the accumulate register
// depends on twdp_pkg
module twdp_datapath #(
    parameter int TILE_COLUMNS = twdp_pkg::TILE_COLUMNS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_data,
    input  twdp_pkg::t_ctrl_cmd                 i_cmd,
    input  logic signed [twdp_pkg::ACT_W-1:0]   i_act_0,
    input  logic signed [twdp_pkg::ACT_W-1:0]   i_act_1,
    input  logic signed [twdp_pkg::ACT_W-1:0]   i_act_2,
    input  logic signed [twdp_pkg::ACT_W-1:0]   i_act_3,
    input  logic [twdp_pkg::WEIGHT_W-1:0]       i_weights_0,
    input  logic [twdp_pkg::WEIGHT_W-1:0]       i_weights_1,
    input  logic [twdp_pkg::WEIGHT_W-1:0]       i_weights_2,
    input  logic [twdp_pkg::WEIGHT_W-1:0]       i_weights_3,
    output logic signed [twdp_pkg::SUM_W-1:0]   o_sum
);

    logic signed [twdp_pkg::ACT_W-1:0]  act [twdp_pkg::DEPTH_ROWS];
    logic [twdp_pkg::GROUP_W-1:0]       group;
    logic [twdp_pkg::SUM_W-1:0]         r_sums [TILE_COLUMNS];
    logic [twdp_pkg::SUM_W-1:0]         lane_term [TILE_COLUMNS];
    logic                               r_accumulate;

    assign act[0] = i_act_0;
    assign act[1] = i_act_1;
    assign act[2] = i_act_2;
    assign act[3] = i_act_3;
    assign group  = {i_weights_3, i_weights_2, i_weights_1, i_weights_0};

    // accumulate mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accumulate <= 1'b0;
        end else if (i_cfg_we) begin
            r_accumulate <= i_cfg_data;
        end
    end

    // per column: four activation times code products, summed
    always_comb begin
        logic signed [twdp_pkg::PROD_W-1:0] prod;
        logic signed [twdp_pkg::TERM_W-1:0] term;
        for (int c = 0; c < TILE_COLUMNS; c++) begin
            term = '0;
            for (int b = 0; b < twdp_pkg::DEPTH_ROWS; b++) begin
                prod = act[b] * $signed({1'b0, twdp_pkg::weight_code(group, c, b)});
                term = term + twdp_pkg::TERM_W'(prod);
            end
            lane_term[c] = twdp_pkg::SUM_W'(term);
        end
    end

    // lanes: add on load, rotate towards column zero on each result taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < TILE_COLUMNS; c++) begin
                r_sums[c] <= '0;
            end
        end else if (i_cmd.load) begin
            for (int c = 0; c < TILE_COLUMNS; c++) begin
                r_sums[c] <= r_sums[c] + lane_term[c];
            end
        end else if (i_cmd.shift) begin
            for (int c = 0; c < TILE_COLUMNS - 1; c++) begin
                r_sums[c] <= r_sums[c + 1];
            end
            // after a full turn the sums are back in place, or cleared
            r_sums[TILE_COLUMNS - 1] <= r_accumulate ? r_sums[0] : '0;
        end
    end

    assign o_sum = $signed(r_sums[0]);

    // the column zero sum holds while nothing is loaded or taken
    a_sums_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_cmd.load && !i_cmd.shift && !$past(!i_rst_n)) |=> $stable(r_sums[0]))
        else $error("column sum changed without command");

    // load and result step never coincide
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.load && i_cmd.shift))
        else $error("load and shift in the same cycle");

endmodule

// ===== verif/twdp_tile_checker.sv =====
// result checker for the two-bit weight dot-product tile
// watches both channels and the accumulate mode writes, predicts the column sums
// and compares every result transaction; depends on twdp_pkg
module twdp_tile_checker #(
    parameter int TILE_COLUMNS = twdp_pkg::TILE_COLUMNS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_data,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic signed [twdp_pkg::ACT_W-1:0]   i_act_0,
    input  logic signed [twdp_pkg::ACT_W-1:0]   i_act_1,
    input  logic signed [twdp_pkg::ACT_W-1:0]   i_act_2,
    input  logic signed [twdp_pkg::ACT_W-1:0]   i_act_3,
    input  logic [twdp_pkg::WEIGHT_W-1:0]       i_weights_0,
    input  logic [twdp_pkg::WEIGHT_W-1:0]       i_weights_1,
    input  logic [twdp_pkg::WEIGHT_W-1:0]       i_weights_2,
    input  logic [twdp_pkg::WEIGHT_W-1:0]       i_weights_3,
    input  logic                                i_last_group,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic [twdp_pkg::COL_W-1:0]          i_column,
    input  logic signed [twdp_pkg::SUM_W-1:0]   i_sum,
    input  logic                                i_last_column,
    output int                                  o_mismatches,
    output int                                  o_results_due,
    output int                                  o_results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [twdp_pkg::COL_W-1:0] column;
        logic [twdp_pkg::SUM_W-1:0] sum;
        logic                       last_column;
    } t_column_result;

    // predicted state of the tile
    logic [twdp_pkg::SUM_W-1:0] column_sums [TILE_COLUMNS];
    logic                       accumulate_mode;
    t_column_result             pending_columns [$];
    int                         mismatches = 0;
    int                         checked = 0;

    // contribution of one weight group to one column: four activations times codes
    function automatic logic [twdp_pkg::SUM_W-1:0] column_term(
        input logic [4*twdp_pkg::ACT_W-1:0] acts,
        input logic [twdp_pkg::GROUP_W-1:0] group,
        input int                           col
    );
        int                 row;
        int                 bit_pos;
        logic [1:0]         code;
        logic signed [31:0] act_ext;
        logic [31:0]        total;
        total = '0;
        // columns past the packed group carry no weights
        if (col < twdp_pkg::WEIGHT_COLUMNS) begin
            for (row = 0; row < twdp_pkg::DEPTH_ROWS; row++) begin
                // byte 4*j+row, field f, for column 8f+j
                bit_pos = 8 * (4 * (col % 8) + row) + 2 * ((col / 8) % 4);
                code    = group[bit_pos +: 2];
                act_ext = $signed(acts[8*row +: 8]);
                total   = total + act_ext * $signed({30'b0, code});
            end
        end
        return total;
    endfunction

    always @(posedge i_clk) begin
        int                           col;
        t_column_result               got;
        t_column_result               want;
        logic [twdp_pkg::GROUP_W-1:0] group;
        logic [4*twdp_pkg::ACT_W-1:0] acts;
        if (!i_rst_n) begin
            for (col = 0; col < TILE_COLUMNS; col++) begin
                column_sums[col] = '0;
            end
            accumulate_mode = 1'b0;
            pending_columns.delete();
        end else begin
            // result transaction against the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                got.column      = i_column;
                got.sum         = i_sum;
                got.last_column = i_last_column;
                if (pending_columns.size() == 0) begin
                    $error("unexpected result: column %0d sum %0d last_column %0b",
                           got.column, $signed(got.sum), got.last_column);
                    mismatches++;
                end else begin
                    want = pending_columns.pop_front();
                    checked++;
                    if (got.column !== want.column) begin
                        $error("column: expected %0d, got %0d", want.column, got.column);
                        mismatches++;
                    end
                    if (got.sum !== want.sum) begin
                        $error("sum: expected %0d, got %0d",
                               $signed(want.sum), $signed(got.sum));
                        mismatches++;
                    end
                    if (got.last_column !== want.last_column) begin
                        $error("last_column: expected %0b, got %0b",
                               want.last_column, got.last_column);
                        mismatches++;
                    end
                end
            end

            if (i_cfg_we) begin
                accumulate_mode = i_cfg_data;
            end

            // input transaction: fold the group into every column
            if (i_in_valid && !i_in_stall) begin
                group = {i_weights_3, i_weights_2, i_weights_1, i_weights_0};
                acts  = {i_act_3, i_act_2, i_act_1, i_act_0};
                for (col = 0; col < TILE_COLUMNS; col++) begin
                    column_sums[col] = column_sums[col] + column_term(acts, group, col);
                end
                if (i_last_group) begin
                    for (col = 0; col < TILE_COLUMNS; col++) begin
                        want.column      = twdp_pkg::COL_W'(col);
                        want.sum         = column_sums[col];
                        want.last_column = (col == TILE_COLUMNS - 1);
                        pending_columns.push_back(want);
                    end
                    if (!accumulate_mode) begin
                        for (col = 0; col < TILE_COLUMNS; col++) begin
                            column_sums[col] = '0;
                        end
                    end
                end
            end
        end
        o_mismatches      <= mismatches;
        o_results_due     <= pending_columns.size();
        o_results_checked <= checked;
    end

endmodule

// ===== verif/two_bit_weight_dot_product_tile_core_test.sv =====
// testbench top for the two-bit weight dot-product tile
// drives directed and random weight groups with random idling on both channels
// and gives the verdict; depends on twdp_pkg, the tile core and twdp_tile_checker
module two_bit_weight_dot_product_tile_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TILE_COLUMNS  = twdp_pkg::TILE_COLUMNS_DEF;
    localparam int RANDOM_GROUPS = 450;
    localparam int PHASES        = 6;
    localparam int MAX_GAP       = 60;
    localparam int MAX_STALL     = 40;
    localparam int SETTLE_CYCLES = 8;
    // every transaction a last group, every result behind the longest stall
    localparam int CYCLE_LIMIT   =
        4 * (500 * (MAX_GAP + 2) + 500 * TILE_COLUMNS * (MAX_STALL + 2));

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_we = 1'b0;
    logic                                cfg_data = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                in_stall;
    logic signed [twdp_pkg::ACT_W-1:0]   act_0 = '0;
    logic signed [twdp_pkg::ACT_W-1:0]   act_1 = '0;
    logic signed [twdp_pkg::ACT_W-1:0]   act_2 = '0;
    logic signed [twdp_pkg::ACT_W-1:0]   act_3 = '0;
    logic [twdp_pkg::WEIGHT_W-1:0]       weights_0 = '0;
    logic [twdp_pkg::WEIGHT_W-1:0]       weights_1 = '0;
    logic [twdp_pkg::WEIGHT_W-1:0]       weights_2 = '0;
    logic [twdp_pkg::WEIGHT_W-1:0]       weights_3 = '0;
    logic                                last_group = 1'b0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic [twdp_pkg::COL_W-1:0]          column;
    logic signed [twdp_pkg::SUM_W-1:0]   sum;
    logic                                last_column;

    int  mismatches;
    int  results_due;
    int  results_checked;
    int  cycle_count = 0;
    int  groups_sent = 0;
    int  tiles_sent = 0;
    int  mode_writes = 0;
    bit  quiet_phase = 1'b0;

    two_bit_weight_dot_product_tile_core #(
        .TILE_COLUMNS (TILE_COLUMNS)
    ) DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_act_0       (act_0),
        .i_act_1       (act_1),
        .i_act_2       (act_2),
        .i_act_3       (act_3),
        .i_weights_0   (weights_0),
        .i_weights_1   (weights_1),
        .i_weights_2   (weights_2),
        .i_weights_3   (weights_3),
        .i_last_group  (last_group),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_column      (column),
        .o_sum         (sum),
        .o_last_column (last_column)
    );

    twdp_tile_checker #(
        .TILE_COLUMNS (TILE_COLUMNS)
    ) u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_act_0           (act_0),
        .i_act_1           (act_1),
        .i_act_2           (act_2),
        .i_act_3           (act_3),
        .i_weights_0       (weights_0),
        .i_weights_1       (weights_1),
        .i_weights_2       (weights_2),
        .i_weights_3       (weights_3),
        .i_last_group      (last_group),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_column          (column),
        .i_sum             (sum),
        .i_last_column     (last_column),
        .o_mismatches      (mismatches),
        .o_results_due     (results_due),
        .o_results_checked (results_checked)
    );

    // 8 ns clock
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // idle length: mostly none or short, now and then long
    function automatic int idle_length(input int longest);
        int pick;
        pick = $urandom_range(0, 99);
        if (quiet_phase || pick < 45) begin
            return 0;
        end else if (pick < 85) begin
            return $urandom_range(1, 3);
        end else if (pick < 96) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, longest);
    endfunction

    // receiver: free runs alternating with stall runs
    initial begin : receiver_stall
        int run;
        forever begin
            out_stall <= 1'b0;
            run = quiet_phase ? 8 : $urandom_range(1, 12);
            repeat (run) @(posedge clk);
            run = idle_length(MAX_STALL);
            if (run > 0) begin
                out_stall <= 1'b1;
                repeat (run) @(posedge clk);
            end
        end
    end

    // every two-bit field holding the same code
    function automatic logic [twdp_pkg::GROUP_W-1:0] uniform_codes(input logic [1:0] code);
        return {(twdp_pkg::GROUP_W / 2){code}};
    endfunction

    // random weights: ternary codes, uniform codes or raw bits
    function automatic logic [twdp_pkg::GROUP_W-1:0] random_group();
        int                           style;
        int                           field;
        logic [twdp_pkg::GROUP_W-1:0] group;
        style = $urandom_range(0, 9);
        for (field = 0; field < twdp_pkg::GROUP_W / 32; field++) begin
            group[32*field +: 32] = $urandom();
        end
        if (style < 4) begin
            for (field = 0; field < twdp_pkg::GROUP_W / 2; field++) begin
                group[2*field +: 2] = 2'($urandom_range(0, 2));
            end
        end else if (style == 4) begin
            group = uniform_codes(2'($urandom_range(0, 3)));
        end
        return group;
    endfunction

    // random activations with the extremes and zero favoured
    function automatic logic [4*twdp_pkg::ACT_W-1:0] random_acts();
        int                           lane;
        int                           pick;
        logic [4*twdp_pkg::ACT_W-1:0] acts;
        for (lane = 0; lane < 4; lane++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                acts[8*lane +: 8] = 8'h7f;
            end else if (pick == 1) begin
                acts[8*lane +: 8] = 8'h80;
            end else if (pick == 2) begin
                acts[8*lane +: 8] = 8'h00;
            end else begin
                acts[8*lane +: 8] = 8'($urandom());
            end
        end
        return acts;
    endfunction

    // one input transaction after a random gap; payload held while stalled
    task automatic send_group(
        input logic [4*twdp_pkg::ACT_W-1:0] acts,
        input logic [twdp_pkg::GROUP_W-1:0] group,
        input logic                         last
    );
        int gap;
        gap = idle_length(MAX_GAP);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        {act_3, act_2, act_1, act_0} <= acts;
        {weights_3, weights_2, weights_1, weights_0} <= group;
        last_group <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        groups_sent++;
        if (last) begin
            tiles_sent++;
        end
    endtask

    // wait until every predicted result has been taken, then let the tile settle
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_accumulate(input logic mode);
        settle();
        cfg_we   <= 1'b1;
        cfg_data <= mode;
        @(posedge clk);
        cfg_we <= 1'b0;
        mode_writes++;
    endtask

    initial begin : stimulus
        int row;
        int phase;
        int budget;
        int tile_len;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: accumulate mode still at its reset value
        // zero weights with extreme activations
        send_group({8'h80, 8'h7f, 8'h80, 8'h7f}, uniform_codes(2'd0), 1'b1);
        // code three on every row at both activation extremes
        send_group({4{8'h7f}}, uniform_codes(2'd3), 1'b1);
        send_group({4{8'h80}}, uniform_codes(2'd3), 1'b1);
        send_group({8'h80, 8'h7f, 8'hff, 8'h01}, uniform_codes(2'd2), 1'b1);
        send_group({4{8'h80}}, uniform_codes(2'd1), 1'b1);
        // one depth row at a time exposes the byte and field mapping
        for (row = 0; row < 4; row++) begin
            send_group(32'h1 << (8 * row), random_group(), 1'b1);
        end
        // a tile spanning several groups
        repeat (3) send_group(random_acts(), random_group(), 1'b0);
        send_group(random_acts(), random_group(), 1'b1);
        // sums carried across tiles, then released
        write_accumulate(1'b1);
        repeat (3) send_group(random_acts(), uniform_codes(2'd3), 1'b1);
        write_accumulate(1'b0);
        send_group({4{8'h7f}}, uniform_codes(2'd3), 1'b1);
        send_group(random_acts(), random_group(), 1'b1);

        // random tiles of varying depth, accumulate mode alternating per phase
        for (phase = 0; phase < PHASES; phase++) begin
            write_accumulate(phase % 2 == 0);
            quiet_phase = (phase == 2);
            budget = RANDOM_GROUPS / PHASES;
            while (budget > 0) begin
                tile_len = $urandom_range(0, 7);
                repeat (tile_len) send_group(random_acts(), random_group(), 1'b0);
                send_group(random_acts(), random_group(), 1'b1);
                budget -= tile_len + 1;
            end
            quiet_phase = 1'b0;
        end

        settle();
        $display("%0d weight groups in %0d tiles driven over %0d accumulate mode settings",
                 groups_sent, tiles_sent, mode_writes + 1);
        $display("%0d column results compared", results_checked);
        if (mismatches == 0 && results_due == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/twdp_pkg.sv
rtl/twdp_ctrl.sv
rtl/twdp_datapath.sv
rtl/two_bit_weight_dot_product_tile_core.sv
verif/twdp_tile_checker.sv
verif/two_bit_weight_dot_product_tile_core_test.sv
